@@ design/tcx_pkg.sv @@
// ----------------------------------------------------------------------------
// tcx_pkg: shared types and constants of the toy CPU execute unit
// Sizes, opcodes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package tcx_pkg;

  localparam int MEM_BYTES   = 65536;
  localparam int NUM_REGS    = 16;
  localparam int DIRECT_REGS = 5;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int RF_AW       = $clog2(NUM_REGS);
  localparam int IN_W        = 48;
  localparam int OUT_W       = 40;

  localparam logic [7:0] OP_MOVE = 8'd1;
  localparam logic [7:0] OP_ADD  = 8'd2;
  localparam logic [7:0] OP_SUB  = 8'd3;
  localparam logic [7:0] OP_MUL  = 8'd4;
  localparam logic [7:0] OP_DIV  = 8'd5;
  localparam logic [7:0] OP_AND  = 8'd6;
  localparam logic [7:0] OP_OR   = 8'd7;
  localparam logic [7:0] OP_NOT  = 8'd8;
  localparam logic [7:0] OP_CMP  = 8'd9;
  localparam logic [7:0] OP_JMP  = 8'd10;
  localparam logic [7:0] OP_IN   = 8'd11;
  localparam logic [7:0] OP_OUT  = 8'd12;

  localparam logic [3:0] JC_ALWAYS = 4'd0;
  localparam logic [3:0] JC_EQ     = 4'd1;
  localparam logic [3:0] JC_GT     = 4'd2;
  localparam logic [3:0] JC_LT     = 4'd3;

  localparam logic [1:0] FLAG_EQ = 2'b00;
  localparam logic [1:0] FLAG_GT = 2'b01;
  localparam logic [1:0] FLAG_LT = 2'b11;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DEC, ST_R1H, ST_R1L, ST_R2H, ST_R2L, ST_RWAIT,
    ST_EXEC, ST_DIV, ST_WB, ST_WRL, ST_FIN
  } state_t;

  typedef enum logic [1:0] {TGT_V1H, TGT_V1L, TGT_V2H, TGT_V2L} rd_tgt_t;

  typedef struct packed {
    logic    ld;
    logic    rf_rd;
    logic    rd_en;
    rd_tgt_t rd_tgt;
    logic    exec;
    logic    div_start;
    logic    wb;
    logic    wr_lo;
    logic    fin;
    logic    clr;
  } cmd_t;

  typedef struct packed {
    logic d_mem;
    logic s_mem;
    logic div_go;
    logic wr_en;
    logic wr_mem;
    logic div_done;
    logic out_busy;
    logic clr_last;
  } sts_t;

endpackage

@@ design/tcx_div.sv @@
// ----------------------------------------------------------------------------
// tcx_div: 16-bit signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module tcx_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  logic [15:0] num_r, num_nxt;
  logic [15:0] den_r, den_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [16:0] rem_sh;

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[15:0], num_r[15]};
    if (start) begin
      num_nxt  = dividend[15] ? 16'(-dividend) : dividend;
      den_nxt  = divisor[15] ? 16'(-divisor) : divisor;
      neg_nxt  = dividend[15] ^ divisor[15];
      rem_nxt  = '0;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        num_nxt = {num_r[14:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        num_nxt = {num_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? 16'(-num_r) : num_r;
endmodule

@@ design/tcx_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcx_ctrl: instruction sequencer
// Walks one instruction through operand fetch, execute and write-back.
// ----------------------------------------------------------------------------
module tcx_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  tcx_pkg::sts_t sts,
  output tcx_pkg::cmd_t cmd
);
  import tcx_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DEC;
      ST_DEC: begin
        if (sts.d_mem)      state_nxt = ST_R1H;
        else if (sts.s_mem) state_nxt = ST_R2H;
        else                state_nxt = ST_EXEC;
      end
      ST_R1H:   state_nxt = ST_R1L;
      ST_R1L:   state_nxt = sts.s_mem ? ST_R2H : ST_RWAIT;
      ST_R2H:   state_nxt = ST_R2L;
      ST_R2L:   state_nxt = ST_RWAIT;
      ST_RWAIT: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = sts.div_go ? ST_DIV : ST_WB;
      ST_DIV:   if (sts.div_done) state_nxt = ST_WB;
      ST_WB:    state_nxt = (sts.wr_en && sts.wr_mem) ? ST_WRL : ST_FIN;
      ST_WRL:   state_nxt = ST_FIN;
      ST_FIN:   if (!sts.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.rd_tgt = TGT_V1H;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.ld    = in_tvalid;
      end
      ST_DEC: cmd.rf_rd = 1'b1;
      ST_R1H: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_tgt = TGT_V1H;
      end
      ST_R1L: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_tgt = TGT_V1L;
      end
      ST_R2H: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_tgt = TGT_V2H;
      end
      ST_R2L: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_tgt = TGT_V2L;
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = sts.div_go;
      end
      ST_WB:  cmd.wb    = 1'b1;
      ST_WRL: cmd.wr_lo = 1'b1;
      ST_FIN: cmd.fin   = !sts.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DEC))
    else $error("accepted word not decoded");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !sts.out_busy) |=> (state_r == ST_IDLE))
    else $error("finished item did not return to idle");
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_tready)
    else $error("input taken during memory clear");
endmodule

@@ design/tcx_dpath.sv @@
// ----------------------------------------------------------------------------
// tcx_dpath: execute datapath
// Register file, byte memory, ALU, divider and the result register.
// ----------------------------------------------------------------------------
module tcx_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tcx_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tcx_pkg::OUT_W-1:0]  out_tdata,
  input  tcx_pkg::cmd_t              cmd,
  output tcx_pkg::sts_t              sts
);
  import tcx_pkg::*;

  logic [15:0] rf_r [NUM_REGS];
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rdata_r;

  logic [7:0]  op_r;
  logic [3:0]  d_r, s_r;
  logic [15:0] imm_r, inv_r;
  logic [15:0] rv1_r, rv2_r, v1_r, v2_r;
  logic        pend_r;
  rd_tgt_t     pend_tgt_r;

  logic        wr_en_r, wr_mem_r, wr_reg_ok_r;
  logic [RF_AW-1:0]  wr_idx_r;
  logic [MEM_AW-1:0] wr_addr_r;
  logic [15:0] wr_val_r;

  logic [15:0] pc_r;
  logic [1:0]  flag_r;
  logic        jmp_r, derr_r, ov_r;
  logic [15:0] oval_r;
  logic        out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic [MEM_AW-1:0] clr_cnt_r;

  logic [MEM_AW-1:0] maddr;
  logic              mwe;
  logic [7:0]        mwdata;
  logic [15:0]       rd_d, rd_s;
  logic              div_done;
  logic [15:0]       div_q;

  // operation decode
  logic        w_en, w_to_s, w_force, jc_ok;
  logic [15:0] w_val, w_rv;
  logic [3:0]  w_sel;
  logic [31:0] prod;

  function automatic logic [15:0] rf_read(input logic [3:0] sel,
                                          input logic [15:0] v);
    rf_read = (int'(sel) < NUM_REGS) ? v : 16'd0;
  endfunction

  assign rd_d = rf_read(d_r, rf_r[d_r[RF_AW-1:0]]);
  assign rd_s = rf_read(s_r, rf_r[s_r[RF_AW-1:0]]);
  assign prod = v1_r * v2_r;

  always_comb begin
    w_en    = 1'b0;
    w_to_s  = 1'b0;
    w_force = 1'b0;
    w_val   = v2_r;
    case (op_r)
      OP_MOVE: begin
        w_en    = 1'b1;
        w_force = (s_r == 4'd0);
        w_val   = (s_r == 4'd0) ? imm_r : v2_r;
      end
      OP_ADD: begin w_en = 1'b1; w_val = v1_r + v2_r; end
      OP_SUB: begin w_en = 1'b1; w_val = v1_r - v2_r; end
      OP_MUL: begin w_en = 1'b1; w_val = prod[15:0]; end
      OP_DIV: w_en = (v2_r != 16'd0);
      OP_AND: begin w_en = 1'b1; w_val = {15'd0, (v1_r != 0) && (v2_r != 0)}; end
      OP_OR:  begin w_en = 1'b1; w_val = {15'd0, (v1_r != 0) || (v2_r != 0)}; end
      OP_NOT: begin
        if (d_r != 4'd0) begin
          w_en  = 1'b1;
          w_val = {15'd0, v1_r == 16'd0};
        end else if (s_r != 4'd0) begin
          w_en   = 1'b1;
          w_to_s = 1'b1;
          w_val  = {15'd0, v2_r == 16'd0};
        end
      end
      OP_IN:  begin w_en = 1'b1; w_val = inv_r; end
      default: ;
    endcase
    w_sel = w_to_s ? s_r : d_r;
    w_rv  = w_to_s ? rv2_r : rv1_r;
  end

  always_comb begin
    case (s_r)
      JC_ALWAYS: jc_ok = 1'b1;
      JC_EQ:     jc_ok = (flag_r == FLAG_EQ);
      JC_GT:     jc_ok = (flag_r == FLAG_GT);
      JC_LT:     jc_ok = (flag_r == FLAG_LT);
      default:   jc_ok = 1'b0;
    endcase
  end

  // single memory port
  always_comb begin
    maddr  = rv1_r[MEM_AW-1:0];
    mwe    = 1'b0;
    mwdata = wr_val_r[15:8];
    if (cmd.clr) begin
      maddr  = clr_cnt_r;
      mwe    = 1'b1;
      mwdata = 8'd0;
    end else if (cmd.wb) begin
      maddr = wr_addr_r;
      mwe   = wr_en_r && wr_mem_r;
    end else if (cmd.wr_lo) begin
      maddr  = wr_addr_r + MEM_AW'(1);
      mwe    = 1'b1;
      mwdata = wr_val_r[7:0];
    end else begin
      case (cmd.rd_tgt)
        TGT_V1H: maddr = rv1_r[MEM_AW-1:0];
        TGT_V1L: maddr = rv1_r[MEM_AW-1:0] + MEM_AW'(1);
        TGT_V2H: maddr = rv2_r[MEM_AW-1:0];
        TGT_V2L: maddr = rv2_r[MEM_AW-1:0] + MEM_AW'(1);
        default: maddr = rv1_r[MEM_AW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwdata;
    rdata_r <= mem[maddr];
  end

  tcx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (v1_r),
    .divisor  (v2_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= '0;
      pc_r         <= '0;
      flag_r       <= FLAG_EQ;
      out_tvalid_r <= 1'b0;
      pend_r       <= 1'b0;
      clr_cnt_r    <= '0;
      wr_en_r      <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
      pend_r <= cmd.rd_en;
      if (cmd.exec) begin
        wr_en_r <= w_en;
        if (op_r == OP_CMP) begin
          if (v1_r == v2_r) flag_r <= FLAG_EQ;
          else if ($signed(v1_r) > $signed(v2_r)) flag_r <= FLAG_GT;
          else flag_r <= FLAG_LT;
        end
        if (op_r == OP_JMP && jc_ok) pc_r <= pc_r + imm_r;
      end
      if (cmd.wb && wr_en_r && !wr_mem_r && wr_reg_ok_r) rf_r[wr_idx_r] <= wr_val_r;
      if (cmd.fin) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      op_r  <= in_tdata[7:0];
      d_r   <= in_tdata[11:8];
      s_r   <= in_tdata[15:12];
      imm_r <= in_tdata[31:16];
      inv_r <= in_tdata[47:32];
    end
    if (cmd.rf_rd) begin
      rv1_r <= rd_d;
      rv2_r <= rd_s;
      v1_r  <= rd_d;
      v2_r  <= (s_r == 4'd0) ? imm_r : rd_s;
    end
    pend_tgt_r <= cmd.rd_tgt;
    if (pend_r) begin
      case (pend_tgt_r)
        TGT_V1H: v1_r[15:8] <= rdata_r;
        TGT_V1L: v1_r[7:0]  <= rdata_r;
        TGT_V2H: v2_r[15:8] <= rdata_r;
        TGT_V2L: v2_r[7:0]  <= rdata_r;
        default: ;
      endcase
    end
    if (cmd.exec) begin
      wr_mem_r    <= !w_force && (int'(w_sel) >= DIRECT_REGS);
      wr_reg_ok_r <= int'(w_sel) < NUM_REGS;
      wr_idx_r    <= w_sel[RF_AW-1:0];
      wr_addr_r   <= w_rv[MEM_AW-1:0];
      wr_val_r    <= w_val;
      jmp_r       <= (op_r == OP_JMP) && jc_ok;
      derr_r      <= (op_r == OP_DIV) && (v2_r == 16'd0);
      ov_r        <= (op_r == OP_OUT);
      oval_r      <= (op_r == OP_OUT) ? v1_r : 16'd0;
    end
    if (div_done) wr_val_r <= div_q;
    if (cmd.fin) out_tdata_r <= {3'd0, derr_r, flag_r, pc_r, jmp_r, oval_r, ov_r};
  end

  always_comb begin
    sts          = '0;
    sts.d_mem    = int'(d_r) >= DIRECT_REGS;
    sts.s_mem    = (s_r != 4'd0) && (int'(s_r) >= DIRECT_REGS);
    sts.div_go   = (op_r == OP_DIV) && (v2_r != 16'd0);
    sts.wr_en    = wr_en_r;
    sts.wr_mem   = wr_mem_r;
    sts.div_done = div_done;
    sts.out_busy = out_tvalid_r && !out_tready;
    sts.clr_last = (clr_cnt_r == MEM_AW'(MEM_BYTES - 1));
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
endmodule

@@ design/toy_cpu_execute_unit.sv @@
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit: execute stage of a small 16-bit CPU
// Runs one decoded instruction per input word on registers and byte memory.
// ----------------------------------------------------------------------------
// After reset the unit clears its data memory one byte per cycle, with
// in_tready low. An accepted word then goes through decode, execute,
// write-back and finish, which registers the result, before idle takes the
// next word. A memory operand adds high and low byte reads and a wait state
// through the single memory port (reads for both operands when both are in
// memory), a memory destination adds a low-byte write state, and a divide
// waits in the bit-serial divider until it is done. The next word is taken
// while the last result still waits on out_tready; its own result then waits
// until the earlier one is taken.
module toy_cpu_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[7:0], dest_sel[11:8], src_sel[15:12], immediate[31:16],
  // in_value[47:32]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_valid[0], out_value[16:1], jumped[17], pc_now[33:18],
  // cmp_flag[35:34], div_error[36]
  output logic [39:0] out_tdata
);
  import tcx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcx_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );
endmodule
